// File: rtl/dlpg_pkg.sv
// ---------------------------------------------------------------------------
// DDA line point generator package
// Widths, sequencer states and helpers shared by the line generator files.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dlpg_pkg;

  localparam int COORD_BITS   = 6;
  localparam int FRAC_BITS    = 16;
  localparam int ACC_BITS     = COORD_BITS + FRAC_BITS;
  localparam int STEP_BITS    = FRAC_BITS + 2;
  localparam int EXT_BITS     = ACC_BITS - STEP_BITS;
  localparam int CNT_BITS     = COORD_BITS + 1;
  localparam int DIV_CNT_BITS = $clog2(ACC_BITS);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ACC_BITS-1:0]   acc_t;
  typedef logic [STEP_BITS-1:0]  step_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_EMIT
  } state_t;

  // A coordinate or the magnitude of a coordinate difference, placed above the fraction bits.
  function automatic acc_t fix_of(input coord_t mag);
    return {mag, {FRAC_BITS{1'b0}}};
  endfunction

  // Sign-extends an increment to the accumulator width.
  function automatic acc_t step_ext(input step_t s);
    return {{EXT_BITS{s[STEP_BITS-1]}}, s};
  endfunction

endpackage

`default_nettype wire

// File: rtl/dlpg_divider.sv
// ---------------------------------------------------------------------------
// DDA line point generator divider
// Restoring divider retiring one quotient bit per cycle, shared by both axes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlpg_divider (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  dlpg_pkg::acc_t  dividend,
  input  dlpg_pkg::coord_t divisor,
  output logic            done,
  output dlpg_pkg::acc_t  quotient
);
  import dlpg_pkg::*;

  logic                    busy_r;
  logic                    done_r;
  logic [DIV_CNT_BITS-1:0] cnt_r;
  coord_t                  rem_r;
  coord_t                  dsr_r;
  acc_t                    quo_r;

  logic [COORD_BITS:0] shifted;
  logic [COORD_BITS:0] diff;
  logic                ge;

  // The remainder stays below the divisor, so the trial value fits in one
  // bit more than a coordinate and the new remainder fits in a coordinate.
  assign shifted = {rem_r, quo_r[ACC_BITS-1]};
  assign diff    = shifted - {1'b0, dsr_r};
  assign ge      = (shifted >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_BITS'(ACC_BITS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dsr_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= ge ? diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
      quo_r <= {quo_r[ACC_BITS-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_no_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while still busy");

  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held for two cycles");

endmodule

`default_nettype wire

// File: rtl/dda_line_point_generator.sv
// ---------------------------------------------------------------------------
// DDA line point generator
// Walks a line segment with fixed-point increments and emits every point.
// ---------------------------------------------------------------------------
// One segment is taken per input transfer, and the block holds in_stall high
// until its last point has been loaded into the output register. A segment
// with steps = max(|dx|, |dy|) gives steps + 1 points: the block takes the
// transfer, makes two passes of the shared restoring divider (one per axis,
// each handing over its quotient when done), then gives one point per cycle
// while the output side does not stall. Equal endpoints skip the divider and
// give a single point. Points are unsigned fixed point with 16 fraction bits,
// and the final point of each segment carries out_last.
`timescale 1ns / 1ps
`default_nettype none

module dda_line_point_generator (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  dlpg_pkg::coord_t in_start_x,
  input  dlpg_pkg::coord_t in_start_y,
  input  dlpg_pkg::coord_t in_end_x,
  input  dlpg_pkg::coord_t in_end_y,
  output logic             out_valid,
  input  logic             out_stall,
  output dlpg_pkg::acc_t   out_point_x,
  output dlpg_pkg::acc_t   out_point_y,
  output logic             out_last
);
  import dlpg_pkg::*;

  state_t state_r, state_nxt;

  coord_t adx_in, ady_in, steps_in;
  logic   negx_in, negy_in, in_accept;

  coord_t ady_r, steps_r;
  logic   negx_r, negy_r;
  step_t  x_step_r, y_step_r;
  acc_t   x_accum_r, y_accum_r;
  cnt_t   points_left_r;

  logic   out_valid_r, out_last_r;
  acc_t   out_point_x_r, out_point_y_r;

  logic   div_start, div_done, emit_load;
  acc_t   div_dividend, div_quotient;
  coord_t div_divisor;
  step_t  q_mag, q_signed;
  logic   q_neg;

  assign negx_in  = (in_end_x < in_start_x);
  assign negy_in  = (in_end_y < in_start_y);
  assign adx_in   = negx_in ? (in_start_x - in_end_x) : (in_end_x - in_start_x);
  assign ady_in   = negy_in ? (in_start_y - in_end_y) : (in_end_y - in_start_y);
  assign steps_in = (adx_in > ady_in) ? adx_in : ady_in;

  assign in_accept = in_valid && !in_stall;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (steps_in == '0) ? ST_EMIT : ST_DIV_X;
        end
      end
      ST_DIV_X: begin
        if (div_done) begin
          state_nxt = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_load && (points_left_r == cnt_t'(1))) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    emit_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        div_start = in_valid && (steps_in != '0);
      end
      ST_DIV_X: begin
        div_start = div_done;
      end
      ST_DIV_Y: begin
        div_start = 1'b0;
      end
      ST_EMIT: begin
        emit_load = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign div_dividend = (state_r == ST_IDLE) ? fix_of(adx_in) : fix_of(ady_r);
  assign div_divisor  = (state_r == ST_IDLE) ? steps_in : steps_r;

  dlpg_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // The quotient never exceeds one in fixed point, so it fits the step width.
  assign q_mag    = div_quotient[STEP_BITS-1:0];
  assign q_neg    = (state_r == ST_DIV_X) ? negx_r : negy_r;
  assign q_signed = q_neg ? (~q_mag + 1'b1) : q_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      points_left_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_accept) begin
        points_left_r <= cnt_t'(steps_in) + 1'b1;
      end else if (emit_load) begin
        points_left_r <= points_left_r - 1'b1;
      end
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ady_r     <= ady_in;
      steps_r   <= steps_in;
      negx_r    <= negx_in;
      negy_r    <= negy_in;
      x_step_r  <= '0;
      y_step_r  <= '0;
      x_accum_r <= fix_of(in_start_x);
      y_accum_r <= fix_of(in_start_y);
    end else begin
      if (div_done && (state_r == ST_DIV_X)) begin
        x_step_r <= q_signed;
      end
      if (div_done && (state_r == ST_DIV_Y)) begin
        y_step_r <= q_signed;
      end
      if (emit_load) begin
        x_accum_r <= x_accum_r + step_ext(x_step_r);
        y_accum_r <= y_accum_r + step_ext(y_step_r);
      end
    end
    if (emit_load) begin
      out_point_x_r <= x_accum_r;
      out_point_y_r <= y_accum_r;
      out_last_r    <= (points_left_r == cnt_t'(1));
    end
  end

  assign out_valid   = out_valid_r;
  assign out_point_x = out_point_x_r;
  assign out_point_y = out_point_y_r;
  assign out_last    = out_last_r;

  a_emit_has_points: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (points_left_r != '0))
    else $error("emitting with no points left");

  a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> ((state_r == ST_DIV_X) || (state_r == ST_DIV_Y)))
    else $error("divider finished outside a divide state");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_load && (points_left_r == cnt_t'(1))) |=> (state_r == ST_IDLE))
    else $error("sequencer did not return to idle after the last point");

  a_accept_loads_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (points_left_r != '0))
    else $error("accepted segment left no points to emit");

endmodule

`default_nettype wire

// File: dv/dda_line_point_generator_test.sv
// ---------------------------------------------------------------------------
// DDA line point generator testbench
// Sends line segments through the input channel with random idling on both
// sides, predicts every point that each segment walks through, and checks
// the points that come out against that prediction in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dda_line_point_generator_test;

  import dlpg_pkg::coord_t;
  import dlpg_pkg::acc_t;
  import dlpg_pkg::FRAC_BITS;

  localparam int RANDOM_SEGMENTS = 270;
  localparam int QUIET_TAIL      = 30;
  localparam int DRAIN_CYCLES    = 100;

  typedef struct {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    bit     hold_off;
  } segment_t;

  typedef struct {
    acc_t x;
    acc_t y;
    logic last;
  } point_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  coord_t in_start_x = '0;
  coord_t in_start_y = '0;
  coord_t in_end_x = '0;
  coord_t in_end_y = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  acc_t   out_point_x;
  acc_t   out_point_y;
  logic   out_last;

  segment_t segments_to_send[$];
  point_t   points_due[$];
  segment_t seg_on_bus;
  bit       quiet = 1'b0;
  int       in_gap = 0;
  int       out_gap = 0;
  int       failures = 0;
  int       segments_sent = 0;
  int       single_points = 0;
  int       points_checked = 0;
  int       stall_cycles = 0;

  dda_line_point_generator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_point_x(out_point_x),
    .out_point_y(out_point_y),
    .out_last   (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Walks one segment the way the hardware does: increments are the axis
  // delta over the step count, truncated toward zero, and the accumulators
  // wrap at the accumulator width.
  function automatic void plot_segment(input segment_t s);
    int     dx;
    int     dy;
    int     span;
    int     x_inc;
    int     y_inc;
    acc_t   x_pos;
    acc_t   y_pos;
    point_t p;
    dx = int'(s.end_x) - int'(s.start_x);
    dy = int'(s.end_y) - int'(s.start_y);
    span = (dx < 0) ? -dx : dx;
    if (((dy < 0) ? -dy : dy) > span) span = (dy < 0) ? -dy : dy;
    x_inc = (span == 0) ? 0 : (dx * (1 << FRAC_BITS)) / span;
    y_inc = (span == 0) ? 0 : (dy * (1 << FRAC_BITS)) / span;
    x_pos = acc_t'(s.start_x) << FRAC_BITS;
    y_pos = acc_t'(s.start_y) << FRAC_BITS;
    for (int k = 0; k <= span; k++) begin
      if (k != 0) begin
        x_pos = x_pos + acc_t'(x_inc);
        y_pos = y_pos + acc_t'(y_inc);
      end
      p.x = x_pos;
      p.y = y_pos;
      p.last = (k == span);
      points_due.push_back(p);
    end
    if (span == 0) single_points++;
  endfunction

  function automatic void add_segment(input int sx, input int sy, input int ex,
                                      input int ey, input bit hold);
    segment_t s;
    s.start_x = coord_t'(sx);
    s.start_y = coord_t'(sy);
    s.end_x = coord_t'(ex);
    s.end_y = coord_t'(ey);
    s.hold_off = hold;
    segments_to_send.push_back(s);
  endfunction

  // A coordinate within three of the given one, kept on the grid.
  function automatic int near(input int c);
    int v;
    v = c + $urandom_range(0, 6) - 3;
    if (v < 0) v = 0;
    if (v > 63) v = 63;
    return v;
  endfunction

  // Driver: presents the next segment once the previous transfer is done.
  always @(posedge clk) begin
    bit go;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      quiet <= (segments_to_send.size() < QUIET_TAIL);
      if (!(in_valid && in_stall)) begin
        if (in_valid) begin
          plot_segment(seg_on_bus);
          segments_sent++;
        end
        go = 1'b0;
        if (in_gap != 0) begin
          in_gap--;
        end else if (segments_to_send.size() != 0) begin
          if (segments_to_send[0].hold_off && points_due.size() != 0) begin
            // Held back until every outstanding point has been transferred.
          end else if (!quiet && $urandom_range(0, 4) == 0) begin
            in_gap = $urandom_range(0, 17);
          end else begin
            go = 1'b1;
          end
        end
        if (go) begin
          seg_on_bus = segments_to_send.pop_front();
          in_start_x <= seg_on_bus.start_x;
          in_start_y <= seg_on_bus.start_y;
          in_end_x <= seg_on_bus.end_x;
          in_end_y <= seg_on_bus.end_y;
        end
        in_valid <= go;
      end
    end
  end

  // Monitor: checks each point transfer and drives output backpressure.
  always @(posedge clk) begin
    point_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (points_due.size() == 0) begin
          $error("unexpected point x=%0h y=%0h last=%0b",
                 out_point_x, out_point_y, out_last);
          failures++;
        end else begin
          want = points_due.pop_front();
          points_checked++;
          if (out_point_x !== want.x) begin
            $error("point_x: expected %0h, actual %0h", want.x, out_point_x);
            failures++;
          end
          if (out_point_y !== want.y) begin
            $error("point_y: expected %0h, actual %0h", want.y, out_point_y);
            failures++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, out_last);
            failures++;
          end
        end
      end
      if (out_gap != 0) begin
        out_gap--;
        out_stall <= 1'b1;
        stall_cycles++;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(0, 17);
        out_stall <= 1'b1;
        stall_cycles++;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int sx;
    int sy;
    int kind;
    // Endpoints at the grid corners, axis-aligned runs, the steepest and
    // shallowest slopes, inexact increments and equal endpoints.
    add_segment(0, 0, 0, 0, 1'b0);
    add_segment(63, 63, 63, 63, 1'b0);
    add_segment(0, 0, 63, 63, 1'b0);
    add_segment(63, 63, 0, 0, 1'b0);
    add_segment(0, 63, 63, 0, 1'b0);
    add_segment(63, 0, 0, 63, 1'b0);
    add_segment(0, 5, 63, 5, 1'b0);
    add_segment(63, 40, 0, 40, 1'b0);
    add_segment(7, 0, 7, 63, 1'b0);
    add_segment(21, 63, 21, 0, 1'b1);
    add_segment(0, 0, 1, 63, 1'b0);
    add_segment(63, 0, 62, 63, 1'b0);
    add_segment(0, 0, 63, 62, 1'b0);
    add_segment(63, 62, 0, 0, 1'b0);
    add_segment(10, 10, 0, 3, 1'b0);
    add_segment(0, 3, 10, 10, 1'b0);
    add_segment(30, 30, 31, 30, 1'b0);
    add_segment(30, 30, 30, 29, 1'b0);
    add_segment(5, 9, 2, 2, 1'b0);
    add_segment(42, 42, 42, 42, 1'b0);
    add_segment(0, 63, 63, 1, 1'b0);
    add_segment(63, 1, 0, 63, 1'b0);
    for (int i = 0; i < RANDOM_SEGMENTS; i++) begin
      kind = $urandom_range(0, 7);
      sx = $urandom_range(0, 63);
      sy = $urandom_range(0, 63);
      if (kind == 0) add_segment(sx, sy, sx, sy, ($urandom_range(0, 39) == 0));
      else if (kind <= 3) add_segment(sx, sy, near(sx), near(sy), ($urandom_range(0, 39) == 0));
      else add_segment(sx, sy, $urandom_range(0, 63), $urandom_range(0, 63),
                       ($urandom_range(0, 39) == 0));
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (segments_to_send.size() != 0 || in_valid) @(posedge clk);
    while (points_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d segments (%0d with equal endpoints), %0d points checked.",
             segments_sent, single_points, points_checked);
    $display("Output side stalled for %0d cycles; %0d failures.", stall_cycles, failures);
    if (failures == 0) begin
      $display("dda_line_point_generator test passed");
    end else begin
      $display("dda_line_point_generator test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d segments queued and %0d points outstanding.",
             segments_to_send.size(), points_due.size());
    $display("dda_line_point_generator test failed");
    $finish;
  end

endmodule

// File: files.f
rtl/dlpg_pkg.sv
rtl/dlpg_divider.sv
rtl/dda_line_point_generator.sv
dv/dda_line_point_generator_test.sv
